// File: rtl/ffba_pkg.sv
package ffba_pkg;

    // Fixed field widths of the request and result transactions
    localparam int REQ_W  = 24;
    localparam int ADDR_W = 32;
    localparam int SEG_W  = 9;
    localparam int NEED_W = REQ_W + 1;
    localparam int CFG_W  = 32;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SEGMENT_BLOCKS = 1'b0;
    localparam logic CFG_BASE_ADDRESS   = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_MEM   = 2'd1;
    localparam status_t ST_BAD_FREE = 2'd2;

endpackage

// File: rtl/ffba_ram.sv
module ffba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/first_fit_block_allocator.sv
// First-fit block allocator. An allocate transaction walks the fragment table once in
// address order (one table entry per cycle through the fragment memory read port); on
// a miss it makes a second walk that merges adjacent fragments and picks the first
// merged one that fits, then updates the tables in S_COMMIT and S_SPLIT and posts the
// result in S_RESP, which waits while out_stall holds a pending result. A request larger
// than NUM_BLOCKS blocks, or a free of a misaligned address or of one NUM_BLOCKS or more
// blocks above the base, is answered from S_IDLE through S_RESP; any other free reads
// the allocation table in S_FREE_RD and S_FREE_CHK. After reset and after every write of
// segment_blocks the tables are cleared in a pass during which in_stall stays high.
// BLOCK_BYTES must be a power of two.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [ffba_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [ffba_pkg::REQ_W-1:0]  request_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0] release_address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [ffba_pkg::ADDR_W-1:0] granted_address,
    output logic [ffba_pkg::SEG_W-1:0]  granted_blocks
);

    localparam int IDX_W       = $clog2(NUM_BLOCKS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LEN_W       = $clog2(NUM_BLOCKS + 1);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int NEED_W      = ffba_pkg::NEED_W;
    localparam int ADDR_W      = ffba_pkg::ADDR_W;
    localparam int REQ_W_LOCAL = ffba_pkg::REQ_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_MERGE, S_MTAIL, S_COMMIT, S_SPLIT,
        S_FREE_RD, S_FREE_CHK, S_RESP
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [ffba_pkg::SEG_W-1:0] seg_reg;
    logic [ADDR_W-1:0]          base_reg;

    // Walk control and per-transaction context
    logic [CNT_W-1:0]  ra_reg, ra_next;
    logic              dv_reg, dv_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [LEN_W-1:0]  slen_reg, slen_next;
    logic              hv_reg, hv_next;
    logic [IDX_W-1:0]  hidx_reg, hidx_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;

    // Result register
    logic                       ov_reg, ov_next;
    ffba_pkg::status_t          st_reg, st_next;
    ffba_pkg::status_t          ost_reg;
    logic [ADDR_W-1:0]          ga_reg, ga_next;
    logic [ffba_pkg::SEG_W-1:0] gb_reg, gb_next;

    // Memory ports
    logic              frag_we, alloc_we;
    logic [IDX_W-1:0]  frag_waddr, alloc_waddr, frag_raddr, alloc_raddr;
    logic [LEN_W-1:0]  frag_wdata, alloc_wdata, frag_rdata, alloc_rdata;

    // Request decode
    logic [REQ_W_LOCAL-1:0] req_low;
    logic [NEED_W-1:0] need_raw, need_in;
    logic [ADDR_W-1:0] free_off;
    logic [ADDR_W-1:0] free_blk;
    logic              free_bad;
    logic              in_accept;
    logic              cfg_seg_wr;

    // Merge helpers
    logic [LEN_W:0]    head_end;
    logic              head_fits;
    logic [LEN_W-1:0]  seg_len;
    logic [LEN_W-1:0]  rest;
    logic              split_wr;
    logic              res_load;

    ffba_ram #(.WIDTH(LEN_W), .DEPTH(NUM_BLOCKS)) u_frag_ram (
        .clk   (clk),
        .we    (frag_we),
        .waddr (frag_waddr),
        .wdata (frag_wdata),
        .raddr (frag_raddr),
        .rdata (frag_rdata)
    );

    ffba_ram #(.WIDTH(LEN_W), .DEPTH(NUM_BLOCKS)) u_alloc_ram (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (alloc_waddr),
        .wdata (alloc_wdata),
        .raddr (alloc_raddr),
        .rdata (alloc_rdata)
    );

    // Round the request up to whole blocks, at least one
    assign req_low  = request_bytes & REQ_W_LOCAL'(BLOCK_BYTES - 1);
    assign need_raw = NEED_W'(request_bytes >> BLOCK_SHIFT) + NEED_W'(req_low != '0);
    assign need_in  = (need_raw == '0) ? NEED_W'(1) : need_raw;

    // Check the release address for block alignment and for a range of NUM_BLOCKS from the base
    assign free_off = release_address - base_reg;
    assign free_blk = free_off >> BLOCK_SHIFT;
    assign free_bad = ((free_off & ADDR_W'(BLOCK_BYTES - 1)) != '0) ||
                      (free_blk >= ADDR_W'(NUM_BLOCKS));

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign cfg_seg_wr = cfg_write && (cfg_index == ffba_pkg::CFG_SEGMENT_BLOCKS);

    assign seg_len  = (32'(seg_reg) > NUM_BLOCKS) ? LEN_W'(NUM_BLOCKS) : LEN_W'(seg_reg);
    assign head_end = (LEN_W + 1)'(hidx_reg) + (LEN_W + 1)'(acc_reg);
    assign head_fits = hv_reg && !found_reg && (NEED_W'(acc_reg) >= need_reg);
    assign rest     = slen_reg - need_reg[LEN_W-1:0];
    assign split_wr = (rest != '0) &&
                      ((NEED_W + 1)'(slot_reg) + (NEED_W + 1)'(need_reg) <
                       (NEED_W + 1)'(NUM_BLOCKS));
    assign res_load = !ov_reg || !out_stall;

    assign frag_raddr  = ra_reg[IDX_W-1:0];
    assign alloc_raddr = slot_reg;

    // Next-state logic and memory writes
    always_comb
    begin
        state_next  = state_reg;
        ra_next     = ra_reg;
        dv_next     = 1'b0;
        didx_next   = didx_reg;
        need_next   = need_reg;
        slot_next   = slot_reg;
        slen_next   = slen_reg;
        hv_next     = hv_reg;
        hidx_next   = hidx_reg;
        acc_next    = acc_reg;
        found_next  = found_reg;
        faddr_next  = faddr_reg;
        ov_next     = ov_reg && out_stall;
        st_next     = st_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        frag_we     = 1'b0;
        frag_waddr  = slot_reg;
        frag_wdata  = '0;
        alloc_we    = 1'b0;
        alloc_waddr = slot_reg;
        alloc_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep both tables; block 0 holds the whole segment
                frag_we     = 1'b1;
                frag_waddr  = ra_reg[IDX_W-1:0];
                frag_wdata  = (ra_reg == '0) ? seg_len : '0;
                alloc_we    = 1'b1;
                alloc_waddr = ra_reg[IDX_W-1:0];
                ra_next     = ra_reg + CNT_W'(1);
                if (ra_reg[IDX_W-1:0] == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ra_next    = '0;
                    need_next  = need_in;
                    faddr_next = release_address;
                    slot_next  = free_blk[IDX_W-1:0];
                    if (action == ffba_pkg::ACT_ALLOC)
                    begin
                        if (need_in > NEED_W'(NUM_BLOCKS))
                        begin
                            st_next    = ffba_pkg::ST_NO_MEM;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (free_bad)
                    begin
                        st_next    = ffba_pkg::ST_BAD_FREE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle, test the entry read last cycle
                if (ra_reg < CNT_W'(NUM_BLOCKS))
                begin
                    ra_next   = ra_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                    didx_next = ra_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    if (frag_rdata != '0 && NEED_W'(frag_rdata) >= need_reg)
                    begin
                        slot_next  = didx_reg;
                        slen_next  = frag_rdata;
                        dv_next    = 1'b0;
                        state_next = S_COMMIT;
                    end
                    else if (didx_reg == IDX_W'(NUM_BLOCKS - 1))
                    begin
                        ra_next    = '0;
                        dv_next    = 1'b0;
                        hv_next    = 1'b0;
                        found_next = 1'b0;
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                if (ra_reg < CNT_W'(NUM_BLOCKS))
                begin
                    ra_next   = ra_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                    didx_next = ra_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    if (frag_rdata != '0)
                    begin
                        if (hv_reg && head_end == (LEN_W + 1)'(didx_reg))
                        begin
                            // Absorb the fragment that starts at the head's end
                            acc_next   = acc_reg + frag_rdata;
                            frag_we    = 1'b1;
                            frag_waddr = didx_reg;
                            frag_wdata = '0;
                        end
                        else
                        begin
                            // Close the previous head and open a new one
                            if (hv_reg)
                            begin
                                frag_we    = 1'b1;
                                frag_waddr = hidx_reg;
                                frag_wdata = acc_reg;
                            end
                            if (head_fits)
                            begin
                                found_next = 1'b1;
                                slot_next  = hidx_reg;
                                slen_next  = acc_reg;
                            end
                            hv_next   = 1'b1;
                            hidx_next = didx_reg;
                            acc_next  = frag_rdata;
                        end
                    end
                    if (didx_reg == IDX_W'(NUM_BLOCKS - 1))
                    begin
                        dv_next    = 1'b0;
                        state_next = S_MTAIL;
                    end
                end
            end
            S_MTAIL:
            begin
                // Close the last head and pick the result
                if (hv_reg)
                begin
                    frag_we    = 1'b1;
                    frag_waddr = hidx_reg;
                    frag_wdata = acc_reg;
                end
                if (head_fits)
                begin
                    slot_next = hidx_reg;
                    slen_next = acc_reg;
                end
                if (found_reg || head_fits)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    st_next    = ffba_pkg::ST_NO_MEM;
                    state_next = S_RESP;
                end
            end
            S_COMMIT:
            begin
                frag_we     = 1'b1;
                frag_wdata  = '0;
                alloc_we    = 1'b1;
                alloc_wdata = need_reg[LEN_W-1:0];
                state_next  = S_SPLIT;
            end
            S_SPLIT:
            begin
                // Leave the tail of the fragment free
                frag_we    = split_wr;
                frag_waddr = IDX_W'((NEED_W + 1)'(slot_reg) + (NEED_W + 1)'(need_reg));
                frag_wdata = rest;
                st_next    = ffba_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (alloc_rdata == '0)
                begin
                    st_next = ffba_pkg::ST_BAD_FREE;
                end
                else
                begin
                    frag_we     = 1'b1;
                    frag_wdata  = alloc_rdata;
                    alloc_we    = 1'b1;
                    alloc_wdata = '0;
                    slen_next   = alloc_rdata;
                    st_next     = ffba_pkg::ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Post the result once the output register is free
                if (res_load)
                begin
                    ov_next = 1'b1;
                    if (st_reg != ffba_pkg::ST_OK)
                    begin
                        ga_next = '0;
                        gb_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A segment size write rebuilds the heap
        if (cfg_seg_wr)
        begin
            ra_next    = '0;
            state_next = S_CLEAR;
        end
    end

    // Result payload selection for a successful transaction
    logic              res_free_reg;
    logic              res_free_next;
    logic [ADDR_W-1:0] res_addr;
    logic [LEN_W-1:0]  res_len;

    assign res_free_next = (state_reg == S_IDLE && in_accept) ? (action == ffba_pkg::ACT_FREE)
                                                              : res_free_reg;
    assign res_addr = res_free_reg ? faddr_reg
                                   : base_reg + (ADDR_W'(slot_reg) << BLOCK_SHIFT);
    assign res_len  = res_free_reg ? slen_reg : need_reg[LEN_W-1:0];

    // State, context and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ra_reg       <= '0;
            dv_reg       <= 1'b0;
            hv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            ov_reg       <= 1'b0;
            seg_reg      <= ffba_pkg::SEG_W'(256);
            base_reg     <= '0;
            res_free_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ra_reg       <= ra_next;
            dv_reg       <= dv_next;
            hv_reg       <= hv_next;
            found_reg    <= found_next;
            ov_reg       <= ov_next;
            res_free_reg <= res_free_next;
            if (cfg_write)
            begin
                if (cfg_index == ffba_pkg::CFG_SEGMENT_BLOCKS)
                begin
                    seg_reg <= cfg_data[ffba_pkg::SEG_W-1:0];
                end
                else
                begin
                    base_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        didx_reg  <= didx_next;
        need_reg  <= need_next;
        slot_reg  <= slot_next;
        slen_reg  <= slen_next;
        hidx_reg  <= hidx_next;
        acc_reg   <= acc_next;
        faddr_reg <= faddr_next;
        st_reg    <= st_next;
        // Hold the posted status until the next result is posted
        if (state_reg == S_RESP && res_load)
        begin
            ost_reg <= st_reg;
        end
        if (state_reg == S_RESP && res_load && st_reg == ffba_pkg::ST_OK)
        begin
            ga_reg <= res_addr;
            gb_reg <= ffba_pkg::SEG_W'(res_len);
        end
        else
        begin
            ga_reg <= ga_next;
            gb_reg <= gb_next;
        end
    end

    assign out_valid       = ov_reg;
    assign status          = ost_reg;
    assign granted_address = ga_reg;
    assign granted_blocks  = gb_reg;

    // The tables change only while a transaction or the clearing pass is in progress
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> (!frag_we && !alloc_we))
        else $error("table write outside of a transaction");

    // When both tables are written together, they are written at the same block
    a_same_block: assert property (@(posedge clk) disable iff (!rst_n)
        (frag_we && alloc_we) |-> (frag_waddr == alloc_waddr))
        else $error("fragment and allocation writes at different blocks");

    // A chosen fragment always covers the request
    a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (slen_reg != '0 && NEED_W'(slen_reg) >= need_reg))
        else $error("committed fragment shorter than the request");

    // A new result is only posted into a free output register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(ost_reg) && $stable(ga_reg) &&
                                   $stable(gb_reg)))
        else $error("pending result overwritten");

endmodule
